/* sv/lfs_pkg.sv */
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared types, codes and constants of the line follower steering unit.
// ----------------------------------------------------------------------------
package lfs_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 15;

  // register indexes of the configuration port
  localparam logic [CfgIndexWidth-1:0] REG_SPEED_MIN   = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_SPEED_MAX   = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_SPEED_BASE  = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_SPEED_RED   = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_SPEED_DIFF  = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_LOST_COUNT  = 3'd5;
  localparam logic [CfgIndexWidth-1:0] REG_FIRST_ANGLE = 3'd6;
  localparam logic [CfgIndexWidth-1:0] REG_FORK_ANGLE  = 3'd7;

  // tracking modes
  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_STRAIGHT = 2'd1;
  localparam logic [1:0] MODE_FORK     = 2'd2;
  localparam logic [1:0] MODE_LOST     = 2'd3;

  // last trusted side
  localparam logic [1:0] SIDE_NONE  = 2'd0;
  localparam logic [1:0] SIDE_LEFT  = 2'd1;
  localparam logic [1:0] SIDE_RIGHT = 2'd2;

  localparam logic [7:0] FORK_LEFT_WHEEL  = 8'd25;
  localparam logic [7:0] FORK_RIGHT_WHEEL = 8'd80;

  localparam logic signed [17:0] HALF_TURN = 18'sd18000;
  localparam logic signed [17:0] FULL_TURN = 18'sd36000;

  // reciprocal of 7 scaled by 2^14, slightly rounded up
  localparam int unsigned Recip7Shift = 14;
  localparam logic [14:0] RECIP7      = 15'd2341;

  // number of quotient bits: the average position never exceeds 7
  localparam int unsigned QuoWidth = 3;

  // datapath commands issued by the controller
  typedef struct packed {
    logic       capture;
    logic       div_step;
    logic [1:0] div_shift;
    logic       update;
    logic       multiply;
    logic       load;
  } lfs_cmd_t;

  typedef struct packed {
    logic count_zero;
  } lfs_status_t;

  // a * 2341: multiplying by this and shifting by 14 gives floor(v * a / 7)
  function automatic logic [14:0] scaled_seventh(input logic [2:0] a);
    logic [17:0] p;
    p = {15'd0, a} * {3'd0, RECIP7};
    return p[14:0];
  endfunction

endpackage

/* sv/lfs_ctrl.sv */
// ----------------------------------------------------------------------------
// lfs_ctrl
// Sequencer of one frame: capture, position divide, mode update, speed
// products and the output register handshake.
// ----------------------------------------------------------------------------
module lfs_ctrl import lfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  lfs_status_t status,
  output lfs_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_UPD  = 5'b00100,
    S_MUL  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t     state, state_next;
  logic [1:0] step, step_next;
  logic       out_valid_next;
  logic       load_ok;

  assign in_ready = (state == S_IDLE);
  assign load_ok  = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    step_next      = step;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.div_shift  = step;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          step_next   = 2'd2;
          state_next  = S_DIV;
        end
      end
      S_DIV: begin
        // an empty frame holds the position, nothing to divide
        if (status.count_zero) begin
          state_next = S_UPD;
        end else begin
          cmd.div_step = 1'b1;
          if (step == 2'd0) begin
            state_next = S_UPD;
          end else begin
            step_next = step - 2'd1;
          end
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.multiply = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (load_ok) begin
          cmd.load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* sv/lfs_datapath.sv */
// ----------------------------------------------------------------------------
// lfs_datapath
// Configuration registers, frame statistics, shift-subtract divider, mode
// and fork tracking state, wheel speed arithmetic and output registers.
// ----------------------------------------------------------------------------
module lfs_datapath import lfs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  input  logic [7:0]               sensor_bits,
  input  logic signed [15:0]       yaw_centideg,
  input  lfs_cmd_t                 cmd,
  output lfs_status_t              status,
  output logic [7:0]               left_speed,
  output logic [7:0]               right_speed,
  output logic [1:0]               track_mode,
  output logic                     fork_turning,
  output logic signed [3:0]        line_position,
  output logic [1:0]               last_side
);

  // configuration
  logic [7:0]  speed_min, speed_max, speed_base, speed_reduction, speed_difference;
  logic [7:0]  lost_confirm_count;
  logic [14:0] first_fork_angle, fork_angle;

  // frame capture
  logic [7:0]         bits_r;
  logic signed [15:0] yaw_r;
  logic [3:0]         count_r;
  logic [2:0]         segs_r;
  logic               neg_r;
  logic [4:0]         rem_r;
  logic [QuoWidth-1:0] quo_r;

  // tracking state
  logic [1:0]         mode_reg;
  logic [7:0]         empty_run;
  logic signed [3:0]  held_position;
  logic [1:0]         side_reg;
  logic               fork_locked;
  logic signed [15:0] fork_start_yaw;
  logic               first_pending;
  logic [14:0]        finish_angle;

  // speed products
  logic [7:0] red_r, dif_r;

  // ---------------- configuration writes ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_min          <= 8'd50;
      speed_max          <= 8'd150;
      speed_base         <= 8'd80;
      speed_reduction    <= 8'd24;
      speed_difference   <= 8'd12;
      lost_confirm_count <= 8'd10;
      first_fork_angle   <= 15'd6500;
      fork_angle         <= 15'd6500;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPEED_MIN:   speed_min          <= cfg_data[7:0];
        REG_SPEED_MAX:   speed_max          <= cfg_data[7:0];
        REG_SPEED_BASE:  speed_base         <= cfg_data[7:0];
        REG_SPEED_RED:   speed_reduction    <= cfg_data[7:0];
        REG_SPEED_DIFF:  speed_difference   <= cfg_data[7:0];
        REG_LOST_COUNT:  lost_confirm_count <= cfg_data[7:0];
        REG_FIRST_ANGLE: first_fork_angle   <= cfg_data;
        REG_FORK_ANGLE:  fork_angle         <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- frame statistics ----------------
  logic [3:0]        in_count;
  logic [2:0]        in_segs;
  logic signed [6:0] in_sum;
  logic signed [6:0] in_mag;

  always_comb begin
    in_count = 4'd0;
    in_segs  = 3'd0;
    in_sum   = 7'sd0;
    for (int i = 0; i < 8; i++) begin
      if (sensor_bits[i]) begin
        in_count = in_count + 4'd1;
        // channel position is 2i - 7
        in_sum   = in_sum + 7'(2 * i - 7);
        if (i == 0 || !sensor_bits[(i == 0) ? 0 : i - 1]) begin
          in_segs = in_segs + 3'd1;
        end
      end
    end
    in_mag = in_sum[6] ? -in_sum : in_sum;
  end

  assign status.count_zero = (count_r == 4'd0);

  // ---------------- divider step ----------------
  logic [5:0] trial;
  assign trial = {2'b00, count_r} << cmd.div_shift;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      bits_r  <= sensor_bits;
      yaw_r   <= yaw_centideg;
      count_r <= in_count;
      segs_r  <= in_segs;
      neg_r   <= in_sum[6];
      rem_r   <= in_mag[4:0];
      quo_r   <= '0;
    end else if (cmd.div_step) begin
      if ({1'b0, rem_r} >= trial) begin
        rem_r                 <= rem_r - trial[4:0];
        quo_r[cmd.div_shift]  <= 1'b1;
      end
    end
  end

  // ---------------- mode and fork update ----------------
  logic [1:0]         mode_n;
  logic [7:0]         empty_n;
  logic signed [3:0]  held_n;
  logic [1:0]         side_n;
  logic               locked_n;
  logic signed [15:0] start_n;
  logic               first_n;
  logic [14:0]        finish_n;
  logic signed [17:0] diff;
  logic signed [17:0] margin;
  logic               single_seg;

  always_comb begin
    mode_n     = mode_reg;
    empty_n    = empty_run;
    held_n     = held_position;
    side_n     = side_reg;
    locked_n   = fork_locked;
    start_n    = fork_start_yaw;
    first_n    = first_pending;
    finish_n   = finish_angle;
    single_seg = (segs_r == 3'd1) && (count_r <= 4'd2);

    if (count_r != 4'd0) begin
      held_n = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
      if (single_seg) begin
        if (held_n < 0) begin
          side_n = SIDE_LEFT;
        end else if (held_n > 0) begin
          side_n = SIDE_RIGHT;
        end
      end
    end

    if (mode_reg != MODE_FORK) begin
      if (count_r == 4'd0) begin
        if (empty_run < lost_confirm_count) begin
          empty_n = empty_run + 8'd1;
        end
        if (empty_n >= lost_confirm_count) begin
          mode_n = MODE_LOST;
        end
      end else if (single_seg) begin
        empty_n = 8'd0;
        mode_n  = MODE_STRAIGHT;
      end else begin
        empty_n = 8'd0;
        mode_n  = MODE_FORK;
      end
    end

    diff = 18'(yaw_r) - 18'(fork_start_yaw);
    if (diff > HALF_TURN) begin
      diff = diff - FULL_TURN;
    end else if (diff < -HALF_TURN) begin
      diff = diff + FULL_TURN;
    end
    margin = diff + $signed({3'b000, finish_angle});

    if (mode_n == MODE_FORK) begin
      if (!fork_locked) begin
        // left right-angle: three leftmost on, three rightmost off
        if (bits_r[2:0] == 3'b111 && bits_r[7:5] == 3'b000) begin
          locked_n = 1'b1;
          start_n  = yaw_r;
          if (first_pending) begin
            finish_n = first_fork_angle;
            first_n  = 1'b0;
          end else begin
            finish_n = fork_angle;
          end
        end else begin
          mode_n = MODE_STRAIGHT;
        end
      end else if (margin <= 18'sd0) begin
        mode_n   = MODE_STRAIGHT;
        locked_n = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg       <= MODE_IDLE;
      empty_run      <= 8'd0;
      held_position  <= 4'sd0;
      side_reg       <= SIDE_NONE;
      fork_locked    <= 1'b0;
      fork_start_yaw <= 16'sd0;
      first_pending  <= 1'b1;
      finish_angle   <= 15'd0;
    end else if (cmd.update) begin
      mode_reg       <= mode_n;
      empty_run      <= empty_n;
      held_position  <= held_n;
      side_reg       <= side_n;
      fork_locked    <= locked_n;
      fork_start_yaw <= start_n;
      first_pending  <= first_n;
      finish_angle   <= finish_n;
    end
  end

  // ---------------- speed products ----------------
  logic [2:0]  abs_pos;
  logic [14:0] scale;
  logic [22:0] red_prod, dif_prod;

  assign abs_pos  = held_position[3] ? 3'(-held_position) : held_position[2:0];
  assign scale    = scaled_seventh(abs_pos);
  assign red_prod = {15'd0, speed_reduction} * {8'd0, scale};
  assign dif_prod = {15'd0, speed_difference} * {8'd0, scale};

  always_ff @(posedge clk) begin
    if (cmd.multiply) begin
      red_r <= red_prod[Recip7Shift+7:Recip7Shift];
      dif_r <= dif_prod[Recip7Shift+7:Recip7Shift];
    end
  end

  // ---------------- clamp and output ----------------
  logic signed [10:0] base, wheel_plus, wheel_minus;
  logic [7:0]         plus_c, minus_c, left_n, right_n;

  function automatic logic [7:0] clamp(input logic signed [10:0] v,
                                       input logic [7:0] lo,
                                       input logic [7:0] hi);
    if (v > $signed({3'b000, hi})) begin
      return hi;
    end else if (v < $signed({3'b000, lo})) begin
      return lo;
    end else begin
      return v[7:0];
    end
  endfunction

  always_comb begin
    base        = $signed({3'b000, speed_base}) - $signed({3'b000, red_r});
    wheel_plus  = base + $signed({3'b000, dif_r});
    wheel_minus = base - $signed({3'b000, dif_r});
    plus_c      = clamp(wheel_plus, speed_min, speed_max);
    minus_c     = clamp(wheel_minus, speed_min, speed_max);
    left_n      = 8'd0;
    right_n     = 8'd0;
    if (mode_reg == MODE_STRAIGHT) begin
      // a left offset speeds up the right wheel
      left_n  = held_position[3] ? minus_c : plus_c;
      right_n = held_position[3] ? plus_c : minus_c;
    end else if (mode_reg == MODE_FORK && fork_locked) begin
      left_n  = FORK_LEFT_WHEEL;
      right_n = FORK_RIGHT_WHEEL;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left_speed    <= left_n;
      right_speed   <= right_n;
      track_mode    <= mode_reg;
      fork_turning  <= fork_locked;
      line_position <= held_position;
      last_side     <= side_reg;
    end
  end

endmodule

/* sv/line_follower_steering_unit.sv */
// ----------------------------------------------------------------------------
// line_follower_steering_unit
// Sensor frame and yaw in, wheel speeds and tracking status out.
// ----------------------------------------------------------------------------
// Each accepted frame yields exactly one result transaction. The line
// position is the signed channel sum divided by the active count. A
// shift-subtract divider does this and resolves one quotient bit per
// cycle; an empty frame has nothing to divide, so no divide step is made.
// Then the mode and fork lock are updated, the speed products are formed
// and the speeds are clamped into the output register. Frames are taken
// only while the sequencer is idle, so a new frame is not taken before
// the last one has reached the output register. A new frame is taken as
// soon as the sequencer is back to idle, while the last result may still
// be waiting to be taken. The result step stalls only if the previous
// result has not yet left. Configuration writes take effect at once and
// are meant to be made while no frame is in flight.
// ----------------------------------------------------------------------------
module line_follower_steering_unit import lfs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               sensor_bits,
  input  logic signed [15:0]       yaw_centideg,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               left_speed,
  output logic [7:0]               right_speed,
  output logic [1:0]               track_mode,
  output logic                     fork_turning,
  output logic signed [3:0]        line_position,
  output logic [1:0]               last_side
);

  lfs_cmd_t    cmd;
  lfs_status_t status;

  lfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lfs_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sensor_bits   (sensor_bits),
    .yaw_centideg  (yaw_centideg),
    .cmd           (cmd),
    .status        (status),
    .left_speed    (left_speed),
    .right_speed   (right_speed),
    .track_mode    (track_mode),
    .fork_turning  (fork_turning),
    .line_position (line_position),
    .last_side     (last_side)
  );

endmodule

/* tb/sv/tb_line_follower_steering_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_line_follower_steering_unit
// Self-checking bench for the line follower steering unit.
// ----------------------------------------------------------------------------
// Sensor frames with yaw are sent through the valid/ready input channel. An
// in-bench predictor tracks position, side, mode and fork lock for every
// accepted frame and queues the expected steering result. Each result
// transaction is checked field by field against the oldest queued
// expectation. A short directed run is followed by random phases under
// several register settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
import lfs_pkg::*;

typedef struct {
  logic [7:0]        left;
  logic [7:0]        right;
  logic [1:0]        mode;
  logic              turning;
  logic signed [3:0] position;
  logic [1:0]        side;
} steer_result_t;

class steering_scoreboard;
  logic [7:0]  spd_min, spd_max, spd_base, spd_red, spd_diff, lost_count;
  logic [14:0] first_angle, later_angle;

  logic [1:0] mode;
  int         empty_run;
  int         held_pos;
  logic [1:0] side;
  bit         locked;
  int         start_yaw;
  bit         first_pending;
  int         finish_angle;

  steer_result_t expected_steer[$];
  int errors, checked, locks;

  function new();
    spd_min = 8'd50;
    spd_max = 8'd150;
    spd_base = 8'd80;
    spd_red = 8'd24;
    spd_diff = 8'd12;
    lost_count = 8'd10;
    first_angle = 15'd6500;
    later_angle = 15'd6500;
    mode = MODE_IDLE;
    empty_run = 0;
    held_pos = 0;
    side = SIDE_NONE;
    locked = 1'b0;
    start_yaw = 0;
    first_pending = 1'b1;
    finish_angle = 0;
    errors = 0;
    checked = 0;
    locks = 0;
  endfunction

  function void set_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgDataWidth-1:0] value);
    case (idx)
      REG_SPEED_MIN:   spd_min = value[7:0];
      REG_SPEED_MAX:   spd_max = value[7:0];
      REG_SPEED_BASE:  spd_base = value[7:0];
      REG_SPEED_RED:   spd_red = value[7:0];
      REG_SPEED_DIFF:  spd_diff = value[7:0];
      REG_LOST_COUNT:  lost_count = value[7:0];
      REG_FIRST_ANGLE: first_angle = value;
      REG_FORK_ANGLE:  later_angle = value;
      default: ;
    endcase
  endfunction

  // max is tested before min, so with an inverted pair any value above max gives max
  function int clamp_speed(int v);
    if (v > int'(spd_max)) return int'(spd_max);
    if (v < int'(spd_min)) return int'(spd_min);
    return v;
  endfunction

  function void note_frame(logic [7:0] bits, logic signed [15:0] yaw);
    int cnt, segs, sum, mag, q, a, base, dif, diff, lsp, rsp, i;
    bit prev;
    steer_result_t want;
    cnt = 0;
    segs = 0;
    sum = 0;
    prev = 1'b0;
    lsp = 0;
    rsp = 0;
    for (i = 0; i < 8; i++) begin
      if (bits[i]) begin
        cnt++;
        sum += 2 * i - 7;
        if (!prev) segs++;
        prev = 1'b1;
      end else begin
        prev = 1'b0;
      end
    end

    // position truncates toward zero and is held over empty frames
    if (cnt != 0) begin
      mag = (sum < 0) ? -sum : sum;
      q = mag / cnt;
      held_pos = (sum < 0) ? -q : q;
      if (segs == 1 && cnt <= 2) begin
        if (held_pos < 0) side = SIDE_LEFT;
        else if (held_pos > 0) side = SIDE_RIGHT;
      end
    end

    if (mode != MODE_FORK) begin
      if (cnt == 0) begin
        if (empty_run < int'(lost_count)) empty_run++;
        if (empty_run >= int'(lost_count)) mode = MODE_LOST;
      end else if (cnt <= 2 && segs == 1) begin
        empty_run = 0;
        mode = MODE_STRAIGHT;
      end else begin
        empty_run = 0;
        mode = MODE_FORK;
      end
    end

    if (mode == MODE_FORK) begin
      if (!locked) begin
        if (bits[2:0] == 3'b111 && bits[7:5] == 3'b000) begin
          locked = 1'b1;
          locks++;
          start_yaw = int'(yaw);
          if (first_pending) begin
            finish_angle = int'(first_angle);
            first_pending = 1'b0;
          end else begin
            finish_angle = int'(later_angle);
          end
        end else begin
          mode = MODE_STRAIGHT;
        end
      end else begin
        // single wrap of the yaw difference
        diff = int'(yaw) - start_yaw;
        if (diff > 18000) diff -= 36000;
        else if (diff < -18000) diff += 36000;
        if (diff <= -finish_angle) begin
          mode = MODE_STRAIGHT;
          locked = 1'b0;
        end
      end
    end

    if (mode == MODE_STRAIGHT) begin
      a = (held_pos < 0) ? -held_pos : held_pos;
      base = int'(spd_base) - (int'(spd_red) * a) / 7;
      dif = (int'(spd_diff) * a) / 7;
      if (held_pos < 0) begin
        lsp = clamp_speed(base - dif);
        rsp = clamp_speed(base + dif);
      end else begin
        lsp = clamp_speed(base + dif);
        rsp = clamp_speed(base - dif);
      end
    end else if (mode == MODE_FORK && locked) begin
      lsp = int'(FORK_LEFT_WHEEL);
      rsp = int'(FORK_RIGHT_WHEEL);
    end

    want.left = 8'(lsp);
    want.right = 8'(rsp);
    want.mode = mode;
    want.turning = locked;
    want.position = 4'(held_pos);
    want.side = side;
    expected_steer.push_back(want);
  endfunction

  function int outstanding();
    return expected_steer.size();
  endfunction

  task report_mismatch(string what);
    errors++;
    if (errors <= 30) $display("mismatch at %0t: %s", $time, what);
  endtask

  task check_result(steer_result_t got);
    steer_result_t want;
    if (expected_steer.size() == 0) begin
      report_mismatch("result transaction with nothing expected");
      return;
    end
    want = expected_steer.pop_front();
    checked++;
    if (got.left !== want.left)
      report_mismatch($sformatf("left_speed %0d, want %0d", got.left, want.left));
    if (got.right !== want.right)
      report_mismatch($sformatf("right_speed %0d, want %0d", got.right, want.right));
    if (got.mode !== want.mode)
      report_mismatch($sformatf("track_mode %0d, want %0d", got.mode, want.mode));
    if (got.turning !== want.turning)
      report_mismatch($sformatf("fork_turning %0b, want %0b", got.turning, want.turning));
    if (got.position !== want.position)
      report_mismatch($sformatf("line_position %0d, want %0d", got.position, want.position));
    if (got.side !== want.side)
      report_mismatch($sformatf("last_side %0d, want %0d", got.side, want.side));
  endtask
endclass

module tb_line_follower_steering_unit;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [7:0]               sensor_bits = '0;
  logic signed [15:0]       yaw_centideg = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [7:0]               left_speed;
  logic [7:0]               right_speed;
  logic [1:0]               track_mode;
  logic                     fork_turning;
  logic signed [3:0]        line_position;
  logic [1:0]               last_side;

  steering_scoreboard sb = new();
  steer_result_t      seen;
  int                 idle_pct = 20;
  int                 frames_sent = 0;
  int                 settings_used = 1;
  int unsigned        setting[8];

  line_follower_steering_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sensor_bits  (sensor_bits),
    .yaw_centideg (yaw_centideg),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .left_speed   (left_speed),
    .right_speed  (right_speed),
    .track_mode   (track_mode),
    .fork_turning (fork_turning),
    .line_position(line_position),
    .last_side    (last_side)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 8);
    return $urandom_range(3, 1);
  endfunction

  function automatic int rand_yaw();
    return int'($urandom_range(36000)) - 18000;
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen.left = left_speed;
      seen.right = right_speed;
      seen.mode = track_mode;
      seen.turning = fork_turning;
      seen.position = line_position;
      seen.side = last_side;
      sb.check_result(seen);
    end
  end

  initial begin
    int stall;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  end

  task automatic send_frame(input logic [7:0] bits, input int yaw);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sensor_bits <= bits;
    yaw_centideg <= 16'(yaw);
    do @(posedge clk); while (!in_ready);
    sb.note_frame(bits, 16'(yaw));
    frames_sent++;
  endtask

  // let every queued result leave, then allow the pipeline to settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic load_setting();
    int i;
    for (i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CfgIndexWidth'(i);
      cfg_data <= CfgDataWidth'(setting[i]);
      @(posedge clk);
      sb.set_reg(CfgIndexWidth'(i), CfgDataWidth'(setting[i]));
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(input int quota);
    int target, kind, len, j, s, y0, d, k, y;
    logic [7:0] b;
    target = frames_sent + quota;
    while (frames_sent < target) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        // tracking: one or two adjacent channels, the odd empty frame
        len = $urandom_range(8, 1);
        for (j = 0; j < len; j++) begin
          s = $urandom_range(7);
          if ($urandom_range(9) == 0) b = 8'h00;
          else if (s < 7 && $urandom_range(1)) b = 8'h03 << s;
          else b = 8'h01 << s;
          send_frame(b, rand_yaw());
        end
      end else if (kind < 55) begin
        len = $urandom_range(int'(sb.lost_count) + 3, 1);
        if (len > 30) len = 30;
        for (j = 0; j < len; j++) send_frame(8'h00, rand_yaw());
      end else if (kind < 80) begin
        // left right-angle fork: try to lock, then turn left in steps
        if ($urandom_range(9) < 3) send_frame(8'h18, rand_yaw());
        y0 = rand_yaw();
        b = 8'h07 | 8'($urandom_range(3) << 3);
        if ($urandom_range(9) == 0) b = b | 8'h20;
        send_frame(b, y0);
        d = int'($urandom_range(22000)) - 2000;
        k = $urandom_range(6, 1);
        for (j = 1; j <= k; j++) begin
          y = y0 - (d * j) / k;
          if (y < -18000) y += 36000;
          else if (y > 18000) y -= 36000;
          send_frame(8'($urandom), y);
        end
      end else begin
        send_frame(8'($urandom), int'($signed(16'($urandom))));
      end
    end
  endtask

  initial begin
    int p;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values: tracking positions, truncation, lost after ten
    send_frame(8'h00, 0);
    send_frame(8'h01, 32767);
    send_frame(8'h80, -32768);
    send_frame(8'h18, 0);
    send_frame(8'h0C, 500);
    send_frame(8'h03, -500);
    send_frame(8'h13, 100);
    send_frame(8'hFF, 0);
    send_frame(8'h55, 0);
    repeat (10) send_frame(8'h00, 0);
    drain();

    setting[REG_SPEED_MIN] = 30;
    setting[REG_SPEED_MAX] = 200;
    setting[REG_SPEED_BASE] = 100;
    setting[REG_SPEED_RED] = 40;
    setting[REG_SPEED_DIFF] = 30;
    setting[REG_LOST_COUNT] = 0;
    setting[REG_FIRST_ANGLE] = 3000;
    setting[REG_FORK_ANGLE] = 9000;
    load_setting();

    // first fork takes the first angle, the second one wraps the yaw
    send_frame(8'h07, 1000);
    send_frame(8'h00, 0);
    send_frame(8'hFF, -2000);
    send_frame(8'h0F, -17000);
    send_frame(8'h07, 17000);
    send_frame(8'h1F, 10000);
    send_frame(8'h00, 0);
    drain();

    for (p = 0; p < 10; p++) begin
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 25;
        default: idle_pct = 70;
      endcase
      if (p == 0) begin
        foreach (setting[i]) setting[i] = 0;
      end else if (p == 1) begin
        foreach (setting[i]) setting[i] = 255;
        setting[REG_FIRST_ANGLE] = 18000;
        setting[REG_FORK_ANGLE] = 18000;
      end else begin
        setting[REG_SPEED_MIN] = $urandom_range(255);
        setting[REG_SPEED_MAX] = $urandom_range(255);
        setting[REG_SPEED_BASE] = $urandom_range(255);
        setting[REG_SPEED_RED] = $urandom_range(255);
        setting[REG_SPEED_DIFF] = $urandom_range(255);
        setting[REG_LOST_COUNT] = $urandom_range(20);
        setting[REG_FIRST_ANGLE] = $urandom_range(18000);
        setting[REG_FORK_ANGLE] = $urandom_range(18000);
        if (p == 2) begin
          // inverted clamp window
          setting[REG_SPEED_MIN] = 200;
          setting[REG_SPEED_MAX] = 40;
          setting[REG_LOST_COUNT] = 3;
        end
      end
      load_setting();
      run_phase(115);
      drain();
    end

    $display("covered %0d frames under %0d register settings with %0d fork locks",
             frames_sent, settings_used, sb.locks);
    $display("%0d result transactions checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/lfs_pkg.sv
sv/lfs_ctrl.sv
sv/lfs_datapath.sv
sv/line_follower_steering_unit.sv
tb/sv/tb_line_follower_steering_unit.sv
